// ===== rtl/bitmap_page_allocator_defines.svh =====
// Assertion macros for the page allocator checker
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int PAGE_SHIFT = 4;
    localparam int NEED_W     = 11;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_UNKNOWN    = 3'd3;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;

    localparam logic OPC_ALLOC   = 1'b0;
    localparam logic OPC_RELEASE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [13:0] request_bytes;
        logic [12:0] release_address;
    } req_t;

    typedef struct packed {
        logic [12:0] block_address;
        logic [2:0]  status;
        logic [13:0] free_bytes;
    } res_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_RUN_RD,
        OP_RUN_EV,
        OP_SLOT_RD,
        OP_SLOT_EV,
        OP_MARK_RD,
        OP_MARK_WR,
        OP_REPLY
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_release;
        logic zero_size;
        logic scan_full;
        logic scan_last;
        logic run_ok;
        logic run_stop;
        logic slot_hit;
        logic slot_last;
        logic mark_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/bpa_ctrl.sv =====
module bpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bpa_pkg::dp_status_t sts,
    output bpa_pkg::dp_cmd_t    cmd
);
    import bpa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_SCAN_RD = 11'b00000000100,
        S_SCAN_EV = 11'b00000001000,
        S_RUN_RD  = 11'b00000010000,
        S_RUN_EV  = 11'b00000100000,
        S_SLOT_RD = 11'b00001000000,
        S_SLOT_EV = 11'b00010000000,
        S_MARK_RD = 11'b00100000000,
        S_MARK_WR = 11'b01000000000,
        S_REPLY   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    if (sts.is_release) state_next = S_SLOT_RD;
                    else if (sts.zero_size) state_next = S_REPLY;
                    else state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.op     = OP_SCAN_RD;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                cmd.op = OP_SCAN_EV;
                if (!sts.scan_full) state_next = S_RUN_EV;
                else if (sts.scan_last) state_next = S_REPLY;
                else state_next = S_SCAN_RD;
            end
            S_RUN_RD: begin
                cmd.op     = OP_RUN_RD;
                state_next = S_RUN_EV;
            end
            S_RUN_EV: begin
                cmd.op = OP_RUN_EV;
                if (sts.run_ok) state_next = S_SLOT_RD;
                else if (sts.run_stop) state_next = sts.scan_last ? S_REPLY : S_SCAN_RD;
                else state_next = S_RUN_RD;
            end
            S_SLOT_RD: begin
                cmd.op     = OP_SLOT_RD;
                state_next = S_SLOT_EV;
            end
            S_SLOT_EV: begin
                cmd.op = OP_SLOT_EV;
                if (sts.slot_hit) state_next = S_MARK_RD;
                else if (sts.slot_last) state_next = S_REPLY;
                else state_next = S_SLOT_RD;
            end
            S_MARK_RD: begin
                cmd.op     = OP_MARK_RD;
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                cmd.op     = OP_MARK_WR;
                state_next = sts.mark_last ? S_REPLY : S_MARK_RD;
            end
            S_REPLY: begin
                if (!sts.out_busy) begin
                    cmd.op     = OP_REPLY;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else state_reg <= state_next;
    end

endmodule

// ===== rtl/bpa_datapath.sv =====
module bpa_datapath #(
    parameter int BITMAP_BYTES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpa_pkg::req_t       s_req,
    input  bpa_pkg::dp_cmd_t    cmd,
    output bpa_pkg::dp_status_t sts,
    output logic                m_valid,
    input  logic                m_ready,
    output bpa_pkg::res_t       m_res
);
    import bpa_pkg::*;

    localparam int BW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int PW = BW + 3;
    localparam int XW = (PW + 5 > 14) ? PW + 5 : 14;
    localparam logic [BW-1:0] LAST_IDX = BW'(BITMAP_BYTES - 1);

    logic [7:0]        bm_mem [BITMAP_BYTES];
    logic              tv_mem [BITMAP_BYTES];
    logic [PW-1:0]     ts_mem [BITMAP_BYTES];
    logic [NEED_W-1:0] tc_mem [BITMAP_BYTES];

    logic [7:0]        bm_q;
    logic              tv_q;
    logic [PW-1:0]     ts_q;
    logic [NEED_W-1:0] tc_q;

    req_t              req_reg;
    logic [NEED_W-1:0] need_reg, remain_reg;
    logic [BW-1:0]     scan_reg, cur_reg, slot_reg, clr_reg;
    logic [2:0]        off_reg;
    logic [PW-1:0]     start_reg;
    logic [PW:0]       free_reg;
    logic [2:0]        status_reg;
    logic [12:0]       addr_reg;
    logic              out_valid_reg;
    res_t              out_reg;

    logic [NEED_W-1:0] need_in;
    logic [2:0]        low_zero;
    logic [7:0]        run_t;
    logic [3:0]        run_z, room;
    logic [3:0]        mark_n;
    logic [7:0]        mark_mask;
    logic              rel_match;
    logic [XW-1:0]     start_bytes, free_full;

    logic              bm_re, bm_we, tbl_re, tv_we, tsc_we;
    logic [BW-1:0]     bm_raddr, bm_waddr, tbl_waddr;
    logic [7:0]        bm_wdata;
    logic              tv_wdata;

    always_comb begin
        need_in = NEED_W'(({1'b0, s_req.request_bytes} + 15'd15) >> PAGE_SHIFT);
        low_zero = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!bm_q[i]) low_zero = 3'(i);
        end
        run_t = 8'(({8'hff, bm_q}) >> off_reg);
        run_z = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (run_t[i]) run_z = 4'(i);
        end
        room = 4'd8 - {1'b0, off_reg};
        mark_n = (remain_reg < NEED_W'(room)) ? remain_reg[3:0] : room;
        mark_mask = 8'(((16'd1 << mark_n) - 16'd1) << off_reg);
        start_bytes = XW'({start_reg, 4'b0000});
        free_full = XW'({free_reg, 4'b0000});
        rel_match = tv_q && (XW'({ts_q, 4'b0000}) == XW'(req_reg.release_address));
    end

    always_comb begin
        sts.clr_last   = (clr_reg == LAST_IDX);
        sts.is_release = (s_req.opcode == OPC_RELEASE);
        sts.zero_size  = (s_req.request_bytes == 14'd0);
        sts.scan_full  = (bm_q == 8'hff);
        sts.scan_last  = (scan_reg == LAST_IDX);
        sts.run_ok     = (NEED_W'(run_z) >= remain_reg);
        sts.run_stop   = (run_z < room) || (cur_reg == LAST_IDX);
        sts.slot_hit   = (req_reg.opcode == OPC_RELEASE) ? rel_match : !tv_q;
        sts.slot_last  = (slot_reg == LAST_IDX);
        sts.mark_last  = (remain_reg == NEED_W'(mark_n));
        sts.out_busy   = out_valid_reg && !m_ready;
    end

    always_comb begin
        bm_re     = 1'b0;
        bm_raddr  = cur_reg;
        bm_we     = 1'b0;
        bm_waddr  = cur_reg;
        bm_wdata  = (req_reg.opcode == OPC_RELEASE) ? (bm_q & ~mark_mask) : (bm_q | mark_mask);
        tbl_re    = 1'b0;
        tv_we     = 1'b0;
        tsc_we    = 1'b0;
        tbl_waddr = slot_reg;
        tv_wdata  = (req_reg.opcode == OPC_ALLOC);
        case (cmd.op)
            OP_CLEAR: begin
                bm_we     = 1'b1;
                bm_waddr  = clr_reg;
                bm_wdata  = 8'h00;
                tv_we     = 1'b1;
                tbl_waddr = clr_reg;
                tv_wdata  = 1'b0;
            end
            OP_SCAN_RD: begin
                bm_re    = 1'b1;
                bm_raddr = scan_reg;
            end
            OP_RUN_RD, OP_MARK_RD: bm_re = 1'b1;
            OP_MARK_WR: bm_we = 1'b1;
            OP_SLOT_RD: tbl_re = 1'b1;
            OP_SLOT_EV: begin
                if (sts.slot_hit) begin
                    tv_we  = 1'b1;
                    tsc_we = (req_reg.opcode == OPC_ALLOC);
                end
            end
            default: bm_re = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
        if (bm_re) bm_q <= bm_mem[bm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tv_we) tv_mem[tbl_waddr] <= tv_wdata;
        if (tsc_we) begin
            ts_mem[tbl_waddr] <= start_reg;
            tc_mem[tbl_waddr] <= need_reg;
        end
        if (tbl_re) begin
            tv_q <= tv_mem[slot_reg];
            ts_q <= ts_mem[slot_reg];
            tc_q <= tc_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg    <= s_req;
                need_reg   <= need_in;
                scan_reg   <= '0;
                slot_reg   <= '0;
                addr_reg   <= 13'd0;
                status_reg <= (s_req.opcode == OPC_ALLOC && sts.zero_size) ?
                              ST_ZERO_SIZE : ST_OK;
            end
            OP_SCAN_EV: begin
                if (!sts.scan_full) begin
                    start_reg  <= {scan_reg, low_zero};
                    cur_reg    <= scan_reg;
                    off_reg    <= low_zero;
                    remain_reg <= need_reg;
                end else if (sts.scan_last) begin
                    status_reg <= ST_NO_SPACE;
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            OP_RUN_EV: begin
                if (sts.run_ok) begin
                    slot_reg <= '0;
                end else if (sts.run_stop) begin
                    if (sts.scan_last) status_reg <= ST_NO_SPACE;
                    else scan_reg <= scan_reg + 1'b1;
                end else begin
                    remain_reg <= remain_reg - NEED_W'(run_z);
                    cur_reg    <= cur_reg + 1'b1;
                    off_reg    <= 3'd0;
                end
            end
            OP_SLOT_EV: begin
                if (sts.slot_hit) begin
                    if (req_reg.opcode == OPC_ALLOC) begin
                        addr_reg   <= start_bytes[12:0];
                        cur_reg    <= start_reg[PW-1:3];
                        off_reg    <= start_reg[2:0];
                        remain_reg <= need_reg;
                    end else begin
                        cur_reg    <= ts_q[PW-1:3];
                        off_reg    <= ts_q[2:0];
                        remain_reg <= tc_q;
                    end
                end else if (sts.slot_last) begin
                    status_reg <= (req_reg.opcode == OPC_ALLOC) ? ST_TABLE_FULL : ST_UNKNOWN;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            OP_MARK_WR: begin
                remain_reg <= remain_reg - NEED_W'(mark_n);
                cur_reg    <= cur_reg + 1'b1;
                off_reg    <= 3'd0;
            end
            default: off_reg <= off_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            free_reg <= (PW+1)'(BITMAP_BYTES * 8);
        end else begin
            if (cmd.op == OP_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cmd.op == OP_SLOT_EV && sts.slot_hit) begin
                if (req_reg.opcode == OPC_ALLOC) free_reg <= free_reg - (PW+1)'(need_reg);
                else free_reg <= free_reg + (PW+1)'(tc_q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_REPLY) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_REPLY) begin
            out_reg.block_address <= addr_reg;
            out_reg.status        <= status_reg;
            out_reg.free_bytes    <= free_full[13:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// First-fit page allocator over a pool of BITMAP_BYTES*8 pages of 16 bytes, one bitmap bit
// per page, with a table of BITMAP_BYTES live blocks. After reset a clearing pass wipes
// the bitmap and the table, one bitmap byte and one table slot at a time; no transaction is
// taken meanwhile. The bitmap and table memories are single-port, each access being a read
// followed by an evaluate or write-back step. An allocate scans the bitmap bytes for a free
// page, checks the candidate run byte by byte, searches the table for a free slot and then
// marks the bitmap bytes of the block; a release searches the table for the address and
// then frees its bitmap bytes. A zero-size allocate goes straight to the reply. One request
// is handled at a time; a finished reply waits in an output register while the next request
// is accepted, and a reply that is still waiting there holds the following one back.
module bitmap_page_allocator #(
    parameter int BITMAP_BYTES = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bpa_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output bpa_pkg::res_t m_res
);
    import bpa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpa_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

endmodule

// ===== rtl/bpa_checker.sv =====
`include "bitmap_page_allocator_defines.svh"

module bpa_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input bpa_pkg::req_t s_req,
    input logic          m_valid,
    input logic          m_ready,
    input bpa_pkg::res_t m_res
);
    import bpa_pkg::*;

    `BPA_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_req), "request dropped")
    `BPA_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_res), "reply dropped")
    `BPA_ASSERT_NOW(a_status, m_valid, m_res.status <= ST_ZERO_SIZE, "bad status code")
    `BPA_ASSERT_NOW(a_addr_zero, m_valid && m_res.status != ST_OK, m_res.block_address == 13'd0,
        "address on failed transaction")
    `BPA_ASSERT_NOW(a_align, m_valid, m_res.block_address[3:0] == 4'd0 &&
        m_res.free_bytes[3:0] == 4'd0, "unaligned reply")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

// ===== dv/bitmap_page_allocator_test.sv =====
module bitmap_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    localparam int POOL_BYTES = 64;
    localparam int POOL_PAGES = POOL_BYTES * 8;
    localparam int SLOTS      = POOL_BYTES;
    localparam int WATCH_MAX  = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_res;

    bit          page_used [POOL_PAGES];
    bit          slot_live [SLOTS];
    int unsigned slot_start [SLOTS];
    int unsigned slot_pages [SLOTS];

    res_t        pending_replies[$];
    int unsigned live_addrs[$];
    int          errors = 0;
    int          idle_cycles = 0;

    bitmap_page_allocator #(.BITMAP_BYTES(POOL_BYTES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(m_res)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned pool_free_bytes();
        int unsigned n;
        n = 0;
        for (int p = 0; p < POOL_PAGES; p++) if (!page_used[p]) n++;
        return n * 16;
    endfunction

    function automatic res_t predict_reply(req_t rq);
        res_t rs;
        int unsigned need, start, len, slot, b;
        bit found;
        rs = '0;
        found = 0;
        start = 0;
        if (rq.opcode == OPC_ALLOC) begin
            if (rq.request_bytes == 0) begin
                rs.status = ST_ZERO_SIZE;
            end else begin
                need = (rq.request_bytes + 15) / 16;
                for (int i = 0; i < POOL_BYTES && !found; i++) begin
                    b = 0;
                    while (b < 8 && page_used[i * 8 + b]) b++;
                    if (b < 8) begin
                        len = 0;
                        while (len < need && i * 8 + b + len < POOL_PAGES
                               && !page_used[i * 8 + b + len]) len++;
                        if (len >= need) begin
                            start = i * 8 + b;
                            found = 1;
                        end
                    end
                end
                if (!found) begin
                    rs.status = ST_NO_SPACE;
                end else begin
                    slot = SLOTS;
                    for (int s = SLOTS - 1; s >= 0; s--) if (!slot_live[s]) slot = s;
                    if (slot == SLOTS) begin
                        rs.status = ST_TABLE_FULL;
                    end else begin
                        for (int k = 0; k < need; k++) page_used[start + k] = 1;
                        slot_live[slot] = 1;
                        slot_start[slot] = start;
                        slot_pages[slot] = need;
                        rs.status = ST_OK;
                        rs.block_address = 13'(start * 16);
                        live_addrs.push_back(start * 16);
                    end
                end
            end
        end else begin
            rs.status = ST_UNKNOWN;
            for (int s = 0; s < SLOTS; s++) begin
                if (rs.status == ST_UNKNOWN && slot_live[s]
                    && slot_start[s] * 16 == rq.release_address) begin
                    for (int k = 0; k < slot_pages[s] && slot_start[s] + k < POOL_PAGES; k++)
                        page_used[slot_start[s] + k] = 0;
                    slot_live[s] = 0;
                    rs.status = ST_OK;
                    for (int j = 0; j < live_addrs.size(); j++)
                        if (live_addrs[j] == rq.release_address) begin
                            live_addrs.delete(j);
                            break;
                        end
                end
            end
        end
        rs.free_bytes = 14'(pool_free_bytes());
        return rs;
    endfunction

    function automatic int short_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        return $urandom_range(0, 4);
    endfunction

    task automatic send_request(bit op, int unsigned bytes, int unsigned addr);
        req_t rq;
        int gap;
        rq.opcode = op;
        rq.request_bytes = bytes[13:0];
        rq.release_address = addr[12:0];
        gap = short_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= rq;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(predict_reply(rq));
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic release_random_live();
        int j;
        j = $urandom_range(0, live_addrs.size() - 1);
        send_request(OPC_RELEASE, $urandom, live_addrs[j]);
    endtask

    task automatic test_directed();
        send_request(OPC_ALLOC, 0, 13'h1fff);
        send_request(OPC_RELEASE, 0, 0);
        send_request(OPC_ALLOC, 8193, 0);
        send_request(OPC_ALLOC, 16383, 0);
        send_request(OPC_ALLOC, 1, 0);
        send_request(OPC_ALLOC, 17, 0);
        send_request(OPC_RELEASE, 0, 1);
        send_request(OPC_RELEASE, 14'h3fff, 16);
        send_request(OPC_RELEASE, 0, 0);
        send_request(OPC_RELEASE, 0, 16);
        send_request(OPC_ALLOC, 8192, 13'h1fff);
        send_request(OPC_ALLOC, 16, 0);
        send_request(OPC_RELEASE, 0, 0);
        send_request(OPC_RELEASE, 0, 0);
        send_request(OPC_ALLOC, 8176, 0);
        send_request(OPC_ALLOC, 16, 0);
        send_request(OPC_ALLOC, 32, 0);
        send_request(OPC_RELEASE, 0, 0);
        send_request(OPC_RELEASE, 0, 8176);
        drain_replies();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++) send_request(OPC_ALLOC, 1, 0);
        send_request(OPC_ALLOC, 5000, 0);
        for (int i = 0; i < 8; i++) release_random_live();
        drain_replies();
        while (live_addrs.size() != 0) release_random_live();
        drain_replies();
    endtask

    task automatic test_random();
        int unsigned r, bytes;
        for (int n = 0; n < 1300; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                case ($urandom_range(0, 9))
                    0: bytes = $urandom_range(0, 16383);
                    1: bytes = $urandom_range(1000, 8192);
                    default: bytes = $urandom_range(1, 400);
                endcase
                send_request(OPC_ALLOC, bytes, $urandom);
            end else if (r < 88 && live_addrs.size() != 0) begin
                release_random_live();
            end else begin
                send_request(OPC_RELEASE, $urandom, $urandom);
            end
            if (n == 700) begin
                drain_replies();
            end
        end
        drain_replies();
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t unexpected reply: expected none, actual %p", $time, m_res);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (m_res.block_address !== want.block_address) begin
                    $display("%0t block_address: expected %0d, actual %0d",
                             $time, want.block_address, m_res.block_address);
                    errors++;
                end
                if (m_res.status !== want.status) begin
                    $display("%0t status: expected %0d, actual %0d",
                             $time, want.status, m_res.status);
                    errors++;
                end
                if (m_res.free_bytes !== want.free_bytes) begin
                    $display("%0t free_bytes: expected %0d, actual %0d",
                             $time, want.free_bytes, m_res.free_bytes);
                    errors++;
                end
            end
        end
        if (!aresetn) m_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 3) m_ready <= 1'b0;
        else if ($urandom_range(0, 2) == 0) m_ready <= ($urandom_range(0, 1) == 1);
        else if (!m_ready && $urandom_range(0, 29) != 0) m_ready <= m_ready;
        else m_ready <= 1'b1;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_random();
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
